@@ sv/hts_pkg.sv @@
`default_nettype none
// ============================================================================
// hts_pkg: shared types and constants for the HVAC thermostat sequencer
// Phase encoding, register indexes, field widths and register reset values.
// ============================================================================
package hts_pkg;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int TEMP_W   = 16;
    localparam int TIME_W   = 32;
    localparam int SECS_W   = 16;
    localparam int HYST_W   = 12;
    localparam int PHASE_W  = 3;
    localparam int CMP_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [HYST_W-1:0] HYST_RESET      = 12'd16;
    localparam logic [SECS_W-1:0] FAN_LEAD_RESET  = 16'd30;
    localparam logic [SECS_W-1:0] FAN_LAG_RESET   = 16'd60;
    localparam logic [SECS_W-1:0] MIN_ON_RESET    = 16'd300;
    localparam logic [SECS_W-1:0] OFF_DELAY_RESET = 16'd300;

    // Requested modes
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 3'd0,
        MODE_HEAT = 3'd1,
        MODE_COOL = 3'd2,
        MODE_FAN  = 3'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HYSTERESIS = 3'd0,
        CFG_FAN_LEAD   = 3'd1,
        CFG_FAN_LAG    = 3'd2,
        CFG_MIN_ON     = 3'd3,
        CFG_OFF_DELAY  = 3'd4
    } cfg_idx_t;

    // Sequencer phases, one-hot
    typedef enum logic [7:0] {
        PH_OFF        = 8'b0000_0001,
        PH_COOL_START = 8'b0000_0010,
        PH_HEAT_START = 8'b0000_0100,
        PH_HEAT       = 8'b0000_1000,
        PH_COOL       = 8'b0001_0000,
        PH_FAN_START  = 8'b0010_0000,
        PH_FAN_STOP   = 8'b0100_0000,
        PH_OFF_DELAY  = 8'b1000_0000
    } phase_t;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] CODE_OFF        = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_COOL_START = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_HEAT_START = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_HEAT       = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_COOL       = 3'd4;
    localparam logic [PHASE_W-1:0] CODE_FAN_START  = 3'd5;
    localparam logic [PHASE_W-1:0] CODE_FAN_STOP   = 3'd6;
    localparam logic [PHASE_W-1:0] CODE_OFF_DELAY  = 3'd7;

    // Relay levels
    typedef struct packed {
        logic supply;
        logic fan;
        logic cool;
        logic heat;
    } relay_t;

    // Map a one-hot phase to its reported code
    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_OFF:        code = CODE_OFF;
            PH_COOL_START: code = CODE_COOL_START;
            PH_HEAT_START: code = CODE_HEAT_START;
            PH_HEAT:       code = CODE_HEAT;
            PH_COOL:       code = CODE_COOL;
            PH_FAN_START:  code = CODE_FAN_START;
            PH_FAN_STOP:   code = CODE_FAN_STOP;
            PH_OFF_DELAY:  code = CODE_OFF_DELAY;
            default:       code = CODE_OFF;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

@@ sv/hvac_thermostat_sequencer.sv @@
`default_nettype none
// ============================================================================
// hvac_thermostat_sequencer: heat/cool/fan thermostat with hysteresis
// Eight-phase sequencer: fan lead, minimum on, run, fan lag and off delay.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries one evaluation per transaction:
//   mode, set_point, temperature and now_seconds. Output channel
//   (out_valid/out_stall) returns one result per evaluation: the held heat and
//   cool flags, the four relay levels and the phase after the step.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data; the
//   port is always ready. Write only while no evaluation is in flight.
//   An evaluation passes through the input register and then the sequencer
//   step that loads the state registers, which double as the result register.
//   Throughput is one evaluation per cycle while the receiver does not stall;
//   the state feedback through the single step stage sets that figure.
//   When the receiver stalls, the result and the state hold, the input
//   register holds one evaluation, and in_stall rises once it is full.
//   Reset returns the sequencer to the off phase with all relays cleared and
//   loads the register defaults; no result is pending after reset.
module hvac_thermostat_sequencer
    import hts_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [MODE_W-1:0]       mode,
    input  wire logic signed [TEMP_W-1:0] set_point,
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic [TIME_W-1:0]       now_seconds,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         heat_call,
    output logic                         cool_call,
    output logic                         heat_enable,
    output logic                         cool_enable,
    output logic                         fan_enable,
    output logic                         supply_enable,
    output logic [PHASE_W-1:0]           phase,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers
    logic [HYST_W-1:0] hyst_reg;
    logic [SECS_W-1:0] fan_lead_reg;
    logic [SECS_W-1:0] fan_lag_reg;
    logic [SECS_W-1:0] min_on_reg;
    logic [SECS_W-1:0] off_delay_reg;

    // Input register
    logic                     in_vld_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [TEMP_W-1:0] sp_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [TIME_W-1:0]        now_reg;

    // Sequencer state, also the result register
    logic          out_vld_reg;
    phase_t        phase_reg,  phase_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [SECS_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic          heat_flag_reg, heat_flag_next;
    logic          cool_flag_reg, cool_flag_next;
    relay_t        relay_reg, relay_next;

    logic step;

    // Advance the step when the result slot is free or being taken
    assign step      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !step;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg      <= HYST_RESET;
            fan_lead_reg  <= FAN_LEAD_RESET;
            fan_lag_reg   <= FAN_LAG_RESET;
            min_on_reg    <= MIN_ON_RESET;
            off_delay_reg <= OFF_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HYSTERESIS: hyst_reg      <= cfg_data[HYST_W-1:0];
                CFG_FAN_LEAD:   fan_lead_reg  <= cfg_data[SECS_W-1:0];
                CFG_FAN_LAG:    fan_lag_reg   <= cfg_data[SECS_W-1:0];
                CFG_MIN_ON:     min_on_reg    <= cfg_data[SECS_W-1:0];
                CFG_OFF_DELAY:  off_delay_reg <= cfg_data[SECS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture an evaluation into the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            sp_reg   <= set_point;
            temp_reg <= temperature;
            now_reg  <= now_seconds;
        end
    end

    // Hysteresis band compares at 18 bits, set point compares at 16 bits
    logic signed [CMP_W-1:0] sp_ext, temp_ext, hyst_ext, low_band, high_band;
    logic below_band, above_band, temp_above_sp, temp_below_sp;

    always_comb
    begin
        sp_ext        = CMP_W'(sp_reg);
        temp_ext      = CMP_W'(temp_reg);
        hyst_ext      = $signed({{(CMP_W-HYST_W){1'b0}}, hyst_reg});
        low_band      = sp_ext - hyst_ext;
        high_band     = sp_ext + hyst_ext;
        below_band    = temp_ext < low_band;
        above_band    = temp_ext > high_band;
        temp_above_sp = temp_reg > sp_reg;
        temp_below_sp = temp_reg < sp_reg;
    end

    // Timer check against the stored elapsed time
    logic timer_done;
    logic [TIME_W-1:0] elapsed_fresh;

    assign timer_done    = elapsed_reg >= {{(TIME_W-SECS_W){1'b0}}, target_reg};
    assign elapsed_fresh = now_reg - start_reg;

    // Sequencer step
    always_comb
    begin
        phase_next     = phase_reg;
        start_next     = start_reg;
        target_next    = target_reg;
        elapsed_next   = elapsed_reg;
        heat_flag_next = heat_flag_reg;
        cool_flag_next = cool_flag_reg;
        relay_next     = relay_reg;

        unique case (phase_reg)
            PH_OFF:
            begin
                relay_next     = '0;
                heat_flag_next = 1'b0;
                cool_flag_next = 1'b0;
                if ((mode_reg == MODE_HEAT && below_band) ||
                    (mode_reg == MODE_COOL && above_band))
                begin
                    phase_next  = PH_FAN_START;
                    target_next = fan_lead_reg;
                    start_next  = now_reg;
                end
                else if (mode_reg == MODE_FAN)
                begin
                    phase_next = PH_FAN_STOP;
                end
            end

            PH_HEAT, PH_COOL:
            begin
                if (phase_reg == PH_HEAT)
                begin
                    relay_next     = '{supply: 1'b1, fan: 1'b1, cool: 1'b0, heat: 1'b1};
                    heat_flag_next = 1'b1;
                end
                else
                begin
                    relay_next     = '{supply: relay_reg.supply, fan: 1'b1,
                                       cool: 1'b1, heat: 1'b0};
                    cool_flag_next = 1'b1;
                end
                elapsed_next = '0;
                // Own mode stops once the set point is passed; other low modes stop now
                if ((phase_reg == PH_HEAT && mode_reg == MODE_HEAT) ||
                    (phase_reg == PH_COOL && mode_reg == MODE_COOL))
                begin
                    if ((phase_reg == PH_HEAT) ? temp_above_sp : temp_below_sp)
                    begin
                        phase_next  = PH_FAN_STOP;
                        target_next = fan_lag_reg;
                        start_next  = now_reg;
                    end
                end
                else if (mode_reg <= MODE_COOL)
                begin
                    phase_next  = PH_FAN_STOP;
                    target_next = fan_lag_reg;
                    start_next  = now_reg;
                end
                else if (mode_reg == MODE_FAN)
                begin
                    phase_next = PH_FAN_STOP;
                end
                else
                begin
                    phase_next = PH_OFF;
                end
            end

            PH_FAN_START, PH_FAN_STOP:
            begin
                relay_next     = '{supply: relay_reg.supply, fan: 1'b1,
                                   cool: 1'b0, heat: 1'b0};
                heat_flag_next = 1'b0;
                cool_flag_next = 1'b0;
                if (mode_reg == MODE_FAN)
                begin
                    phase_next = PH_FAN_STOP;
                end
                else if (mode_reg <= MODE_COOL)
                begin
                    if (timer_done)
                    begin
                        elapsed_next = '0;
                        start_next   = now_reg;
                        if (phase_reg == PH_FAN_START)
                        begin
                            target_next = min_on_reg;
                            if (mode_reg == MODE_COOL)
                                phase_next = PH_COOL_START;
                            else if (mode_reg == MODE_HEAT)
                                phase_next = PH_HEAT_START;
                            else
                                phase_next = PH_OFF_DELAY;
                        end
                        else
                        begin
                            target_next = off_delay_reg;
                            phase_next  = PH_OFF_DELAY;
                        end
                    end
                    else
                    begin
                        elapsed_next = elapsed_fresh;
                    end
                end
                else
                begin
                    phase_next = PH_OFF;
                end
            end

            PH_OFF_DELAY:
            begin
                relay_next     = '0;
                heat_flag_next = 1'b0;
                cool_flag_next = 1'b0;
                if (timer_done)
                    phase_next = PH_OFF;
                else
                    elapsed_next = elapsed_fresh;
            end

            PH_COOL_START:
            begin
                relay_next     = '{supply: relay_reg.supply, fan: 1'b1,
                                   cool: 1'b1, heat: 1'b0};
                cool_flag_next = 1'b1;
                if (timer_done)
                    phase_next = PH_COOL;
                else
                    elapsed_next = elapsed_fresh;
            end

            PH_HEAT_START:
            begin
                relay_next     = '{supply: 1'b1, fan: 1'b1, cool: 1'b0, heat: 1'b1};
                heat_flag_next = 1'b1;
                if (timer_done)
                    phase_next = PH_HEAT;
                else
                    elapsed_next = elapsed_fresh;
            end

            default:
            begin
                phase_next = PH_OFF;
            end
        endcase
    end

    // Load the state and result on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            phase_reg     <= PH_OFF;
            start_reg     <= '0;
            target_reg    <= '0;
            elapsed_reg   <= '0;
            heat_flag_reg <= 1'b0;
            cool_flag_reg <= 1'b0;
            relay_reg     <= '0;
        end
        else
        begin
            if (step)
            begin
                out_vld_reg   <= 1'b1;
                phase_reg     <= phase_next;
                start_reg     <= start_next;
                target_reg    <= target_next;
                elapsed_reg   <= elapsed_next;
                heat_flag_reg <= heat_flag_next;
                cool_flag_reg <= cool_flag_next;
                relay_reg     <= relay_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Drive the result fields from the state
    assign out_valid     = out_vld_reg;
    assign heat_call     = heat_flag_reg;
    assign cool_call     = cool_flag_reg;
    assign heat_enable   = relay_reg.heat;
    assign cool_enable   = relay_reg.cool;
    assign fan_enable    = relay_reg.fan;
    assign supply_enable = relay_reg.supply;
    assign phase         = phase_code(phase_reg);

endmodule
`default_nettype wire
